// ===== hw/rtl/whsp_pkg.sv =====
// Shared types and constants for the WebSocket frame header parser.
package whsp_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned LenW     = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CntW     = 4;

  localparam logic [3:0] OpLastData  = 4'd2;
  localparam logic [3:0] OpFirstCtrl = 4'd8;
  localparam logic [3:0] OpLastCtrl  = 4'd10;
  localparam logic [6:0] CtrlMaxLen  = 7'd125;
  localparam logic [6:0] Len16Code   = 7'd126;
  localparam logic [6:0] Len64Code   = 7'd127;

  localparam logic [CntW-1:0] Len16Bytes = 4'd2;
  localparam logic [CntW-1:0] Len64Bytes = 4'd8;
  localparam logic [CntW-1:0] KeyBytes   = 4'd4;

  localparam logic [LenW-1:0] MaxPayloadRst = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRequireMasking = 1'd0,
    CfgMaxPayload     = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhExtLen = 2'd2,
    PhKey    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StMore = 2'd0,
    StDone = 2'd1,
    StErr  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrRsv      = 3'd1,
    ErrOpcode   = 3'd2,
    ErrFragCtrl = 3'd3,
    ErrCtrlLen  = 3'd4,
    ErrPayload  = 3'd5
  } err_e;

  typedef struct packed {
    logic            require_masking;
    logic [LenW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [2:0]      error_code;
    logic            fin_flag;
    logic [3:0]      frame_opcode;
    logic            mask_flag;
    logic [LenW-1:0] payload_length;
    logic [KeyW-1:0] masking_key;
  } res_t;

endpackage

// ===== hw/rtl/whsp_if.sv =====
// Channel interfaces: header byte input, decoded result output, register writes.
interface whsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface whsp_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [2:0]                error_code;
  logic                      fin_flag;
  logic [3:0]                frame_opcode;
  logic                      mask_flag;
  logic [whsp_pkg::LenW-1:0] payload_length;
  logic [whsp_pkg::KeyW-1:0] masking_key;
  modport source (output valid, output status, output error_code, output fin_flag,
                  output frame_opcode, output mask_flag, output payload_length,
                  output masking_key, input ready);
  modport sink (input valid, input status, input error_code, input fin_flag,
                input frame_opcode, input mask_flag, input payload_length,
                input masking_key, output ready);
endinterface

interface whsp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [whsp_pkg::CfgIdxW-1:0] index;
  logic [whsp_pkg::LenW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/websocket_header_parser_unit.sv =====
// Top level of the WebSocket frame header parser.
// A byte passes through the input register and then the result register before its result is valid.
// Throughput: one header byte per cycle while the result output is not stalled; each byte gives one result.
// The input register, if it is empty, accepts a new byte while a finished result still waits downstream.
// Reset (rst_ni low, asynchronous) empties both registers, expects a first header byte,
// and restores require_masking to 0 and max_payload to all ones.
module websocket_header_parser_unit (
  input logic          clk_i,
  input logic          rst_ni,
  whsp_in_if.sink      in_i,
  whsp_out_if.source   out_o,
  whsp_cfg_if.sink     cfg_i
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           out_valid_q;
  whsp_pkg::res_t out_res_q;
  whsp_pkg::res_t res;
  whsp_pkg::cfg_t cfg;
  logic           adv;

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_byte_q <= in_i.data_byte;
  end

  whsp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  whsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_res_q <= res;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_res_q.status;
  assign out_o.error_code     = out_res_q.error_code;
  assign out_o.fin_flag       = out_res_q.fin_flag;
  assign out_o.frame_opcode   = out_res_q.frame_opcode;
  assign out_o.mask_flag      = out_res_q.mask_flag;
  assign out_o.payload_length = out_res_q.payload_length;
  assign out_o.masking_key    = out_res_q.masking_key;

endmodule

// ===== hw/rtl/whsp_cfg.sv =====
// Configuration registers of the header parser.
module whsp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_valid_i,
  output logic                         wr_ready_o,
  input  logic [whsp_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [whsp_pkg::LenW-1:0]    wr_data_i,
  output whsp_pkg::cfg_t               cfg_o
);

  logic                      require_masking_q;
  logic [whsp_pkg::LenW-1:0] max_payload_q;

  assign wr_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_masking_q <= 1'b0;
      max_payload_q     <= whsp_pkg::MaxPayloadRst;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        whsp_pkg::CfgRequireMasking: require_masking_q <= wr_data_i[0];
        whsp_pkg::CfgMaxPayload:     max_payload_q     <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.require_masking = require_masking_q;
  assign cfg_o.max_payload     = max_payload_q;

endmodule

// ===== hw/rtl/whsp_core.sv =====
// Header decode state and the per-byte check and status logic.
module whsp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  whsp_pkg::cfg_t       cfg_i,
  output whsp_pkg::res_t       res_o
);

  whsp_pkg::phase_e              phase_q, phase_d;
  logic [whsp_pkg::CntW-1:0]     bytes_left_q, bytes_left_d;
  logic [7:0]                    first_hold_q, first_hold_d;
  logic                          fin_q, fin_d;
  logic [3:0]                    op_q, op_d;
  logic                          masked_q, masked_d;
  logic [whsp_pkg::LenW-1:0]     length_q, length_d;
  logic [whsp_pkg::KeyW-1:0]     key_q, key_d;

  whsp_pkg::status_e             status;
  whsp_pkg::err_e                err;

  logic                          ctrl;
  logic [6:0]                    code;
  logic                          rsv_bad, op_bad, frag_bad, mask_bad, ctl_long, ext_form;
  logic [whsp_pkg::LenW-1:0]     ext_len;
  logic [whsp_pkg::KeyW-1:0]     key_shift;
  logic                          last_byte, too_big;

  assign ctrl      = op_q[3];
  assign code      = byte_i[6:0];
  assign rsv_bad   = first_hold_q[6:4] != 3'd0;
  assign op_bad    = !(op_q inside {[4'd0 : whsp_pkg::OpLastData],
                                    [whsp_pkg::OpFirstCtrl : whsp_pkg::OpLastCtrl]});
  assign frag_bad  = ctrl && !fin_q;
  assign mask_bad  = cfg_i.require_masking && !byte_i[7];
  assign ctl_long  = ctrl && (code > whsp_pkg::CtrlMaxLen);
  assign ext_form  = (code == whsp_pkg::Len16Code) || (code == whsp_pkg::Len64Code);
  assign ext_len   = {length_q[whsp_pkg::LenW-9:0], byte_i};
  assign key_shift = {key_q[whsp_pkg::KeyW-9:0], byte_i};
  assign last_byte = bytes_left_q == whsp_pkg::CntW'(1);
  assign too_big   = ext_len > cfg_i.max_payload;

  // Status and error code for the byte at hand
  always_comb begin
    status = whsp_pkg::StMore;
    err    = whsp_pkg::ErrNone;
    case (phase_q)
      whsp_pkg::PhSecond: begin
        if (rsv_bad) begin
          status = whsp_pkg::StErr;
          err    = whsp_pkg::ErrRsv;
        end else if (op_bad) begin
          status = whsp_pkg::StErr;
          err    = whsp_pkg::ErrOpcode;
        end else if (frag_bad) begin
          status = whsp_pkg::StErr;
          err    = whsp_pkg::ErrFragCtrl;
        end else if (mask_bad) begin
          status = whsp_pkg::StErr;
          err    = whsp_pkg::ErrOpcode;
        end else if (ctl_long) begin
          status = whsp_pkg::StErr;
          err    = whsp_pkg::ErrCtrlLen;
        end else if (!ext_form && !byte_i[7]) begin
          status = whsp_pkg::StDone;
        end
      end
      whsp_pkg::PhExtLen: begin
        if (last_byte) begin
          if (too_big) begin
            status = whsp_pkg::StErr;
            err    = whsp_pkg::ErrPayload;
          end else if (!masked_q) begin
            status = whsp_pkg::StDone;
          end
        end
      end
      whsp_pkg::PhKey: begin
        if (last_byte) status = whsp_pkg::StDone;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    first_hold_d = first_hold_q;
    fin_d        = fin_q;
    op_d         = op_q;
    masked_d     = masked_q;
    length_d     = length_q;
    key_d        = key_q;
    case (phase_q)
      whsp_pkg::PhSecond: begin
        masked_d = byte_i[7];
        key_d    = '0;
        length_d = {{(whsp_pkg::LenW-7){1'b0}}, code};
        if (status == whsp_pkg::StMore) begin
          if (ext_form) begin
            phase_d      = whsp_pkg::PhExtLen;
            bytes_left_d = (code == whsp_pkg::Len16Code) ? whsp_pkg::Len16Bytes
                                                         : whsp_pkg::Len64Bytes;
            length_d     = '0;
          end else begin
            phase_d      = whsp_pkg::PhKey;
            bytes_left_d = whsp_pkg::KeyBytes;
          end
        end
      end
      whsp_pkg::PhExtLen: begin
        length_d     = ext_len;
        bytes_left_d = bytes_left_q - whsp_pkg::CntW'(1);
        if (last_byte && status == whsp_pkg::StMore) begin
          phase_d      = whsp_pkg::PhKey;
          bytes_left_d = whsp_pkg::KeyBytes;
        end
      end
      whsp_pkg::PhKey: begin
        key_d        = key_shift;
        bytes_left_d = bytes_left_q - whsp_pkg::CntW'(1);
      end
      default: begin
        first_hold_d = byte_i;
        fin_d        = byte_i[7];
        op_d         = byte_i[3:0];
        phase_d      = whsp_pkg::PhSecond;
        bytes_left_d = '0;
      end
    endcase
    if (status != whsp_pkg::StMore) phase_d = whsp_pkg::PhFirst;
  end

  // Result fields, decoded values shown only with a complete header
  always_comb begin
    res_o            = '0;
    res_o.status     = status;
    res_o.error_code = err;
    if (status == whsp_pkg::StDone) begin
      res_o.fin_flag       = fin_d;
      res_o.frame_opcode   = op_d;
      res_o.mask_flag      = masked_d;
      res_o.payload_length = length_d;
      res_o.masking_key    = masked_d ? key_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= whsp_pkg::PhFirst;
      bytes_left_q <= '0;
      first_hold_q <= '0;
      fin_q        <= 1'b0;
      op_q         <= '0;
      masked_q     <= 1'b0;
      length_q     <= '0;
      key_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      first_hold_q <= first_hold_d;
      fin_q        <= fin_d;
      op_q         <= op_d;
      masked_q     <= masked_d;
      length_q     <= length_d;
      key_q        <= key_d;
    end
  end

endmodule
